[src/usbrxd_pkg.sv]
// Shared types and constants for the USB Ethernet receive deframer.
// Used by usbrxd_parser and usb_ether_rx_deframer; no dependencies.
package usbrxd_pkg;

  localparam int MAX_BUFFER_DEF = 32768;
  localparam int MIN_FRAME_DEF  = 6;

  // frame_format register codes
  localparam logic [1:0] FMT_PLAIN  = 2'd0;
  localparam logic [1:0] FMT_CMPL   = 2'd1;
  localparam logic [1:0] FMT_STATUS = 2'd2;

  // event codes on the result
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_DROPPED = 2'd1;
  localparam logic [1:0] EV_SKIPPED = 2'd2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_buffer;
    logic [15:0] buffer_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       has_byte;
    logic       frame_end;
    logic [1:0] event_res;
  } out_item_t;

endpackage

[src/usbrxd_parser.sv]
// Byte-at-a-time buffer parser: header decode, frame/pad/skip tracking.
// Depends on usbrxd_pkg.
module usbrxd_parser #(
  parameter int MAX_BUFFER = usbrxd_pkg::MAX_BUFFER_DEF,
  parameter int MIN_FRAME  = usbrxd_pkg::MIN_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  usbrxd_pkg::in_item_t  item,
  input  logic [1:0]            frame_format,
  output logic                  res_valid,
  output usbrxd_pkg::out_item_t res
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_SKIP    = 3'd3;
  localparam logic [2:0] PH_PAD     = 3'd4;
  localparam logic [2:0] PH_DISCARD = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [15:0] buffer_left, buffer_left_next;
  logic [31:0] header_shift, header_shift_next;
  logic [1:0]  header_count, header_count_next;
  logic [15:0] frame_left, frame_left_next;
  logic [1:0]  pad_left, pad_left_next;
  logic        last_frame_cut, last_frame_cut_next;

  logic [15:0] len, pre;
  logic [16:0] hdr_len, room;
  logic        hdr_ok, hdr_err, run;
  logic        has, fend;
  logic [1:0]  ev;
  logic        hdr_header_mode;

  assign hdr_header_mode = (frame_format == usbrxd_pkg::FMT_CMPL) ||
                           (frame_format == usbrxd_pkg::FMT_STATUS);

  always_comb begin
    phase_next          = phase;
    buffer_left_next    = buffer_left;
    header_shift_next   = header_shift;
    header_count_next   = header_count;
    frame_left_next     = frame_left;
    pad_left_next       = pad_left;
    last_frame_cut_next = last_frame_cut;
    has     = 1'b0;
    fend    = 1'b0;
    ev      = usbrxd_pkg::EV_NONE;
    run     = 1'b1;
    len     = item.buffer_length;
    pre     = '0;
    hdr_len = '0;
    room    = '0;
    hdr_ok  = 1'b0;
    hdr_err = 1'b0;

    if (item.first_of_buffer) begin
      if (item.buffer_length == 16'd0) begin
        len = 16'd1;
      end else if (item.buffer_length > 16'(MAX_BUFFER)) begin
        len = 16'(MAX_BUFFER);
      end
      buffer_left_next    = len;
      pad_left_next       = 2'd0;
      last_frame_cut_next = 1'b0;
      frame_left_next     = 16'd0;
      if (hdr_header_mode) begin
        phase_next        = PH_HEADER;
        header_count_next = 2'd0;
        header_shift_next = 32'd0;
      end else if (len < 16'(MIN_FRAME)) begin
        phase_next = PH_DISCARD;
        ev         = usbrxd_pkg::EV_DROPPED;
      end else begin
        phase_next          = PH_DATA;
        frame_left_next     = len;
        last_frame_cut_next = 1'b1;
      end
    end else if (phase == PH_IDLE || buffer_left == 16'd0) begin
      phase_next = PH_IDLE;
      run        = 1'b0;
    end

    if (run) begin
      pre              = buffer_left_next;
      buffer_left_next = pre - 16'd1;
      unique case (phase_next)
        PH_HEADER: begin
          if (header_count_next == 2'd0 && pre < 16'd4) begin
            ev         = usbrxd_pkg::EV_DROPPED;
            phase_next = PH_DISCARD;
          end else begin
            header_shift_next = {item.data_byte, header_shift_next[31:8]};
            if (header_count_next == 2'd3) begin
              header_count_next = 2'd0;
              // decode the completed 4-byte header
              if (frame_format == usbrxd_pkg::FMT_CMPL) begin
                hdr_ok  = header_shift_next[15:0] == ~header_shift_next[31:16];
                hdr_len = (17'(header_shift_next[15:0]) + 17'd1) & ~17'd1;
              end else if (frame_format == usbrxd_pkg::FMT_STATUS) begin
                hdr_ok  = 1'b1;
                hdr_len = 17'(header_shift_next[31:16]);
                hdr_err = header_shift_next[15];
              end
              room = 17'(buffer_left_next) - hdr_len;
              if (!hdr_ok || hdr_len < 17'(MIN_FRAME) ||
                  hdr_len > 17'(buffer_left_next)) begin
                phase_next = PH_DISCARD;
                ev         = usbrxd_pkg::EV_DROPPED;
              end else begin
                last_frame_cut_next = room < 17'd4;
                pad_left_next = (frame_format == usbrxd_pkg::FMT_STATUS) ?
                                2'(~hdr_len[1:0] + 2'd1) : 2'd0;
                frame_left_next = hdr_len[15:0];
                if (hdr_err) begin
                  phase_next = PH_SKIP;
                  ev         = usbrxd_pkg::EV_SKIPPED;
                end else begin
                  phase_next = PH_DATA;
                end
              end
            end else begin
              header_count_next = header_count_next + 2'd1;
            end
          end
        end
        PH_DATA, PH_SKIP: begin
          has             = (phase_next == PH_DATA);
          frame_left_next = frame_left_next - 16'd1;
          if (frame_left_next == 16'd0) begin
            fend = has;
            priority if (last_frame_cut_next) begin
              phase_next = PH_DISCARD;
            end else if (pad_left_next != 2'd0) begin
              phase_next = PH_PAD;
            end else begin
              phase_next        = PH_HEADER;
              header_count_next = 2'd0;
              header_shift_next = 32'd0;
            end
          end
        end
        PH_PAD: begin
          pad_left_next = pad_left_next - 2'd1;
          if (pad_left_next == 2'd0) begin
            phase_next        = PH_HEADER;
            header_count_next = 2'd0;
            header_shift_next = 32'd0;
          end
        end
        default: begin
        end
      endcase
      if (buffer_left_next == 16'd0) begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      buffer_left    <= '0;
      header_shift   <= '0;
      header_count   <= '0;
      frame_left     <= '0;
      pad_left       <= '0;
      last_frame_cut <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      buffer_left    <= buffer_left_next;
      header_shift   <= header_shift_next;
      header_count   <= header_count_next;
      frame_left     <= frame_left_next;
      pad_left       <= pad_left_next;
      last_frame_cut <= last_frame_cut_next;
    end
  end

  assign res_valid      = step && (has || ev != usbrxd_pkg::EV_NONE);
  assign res.frame_byte = has ? item.data_byte : 8'd0;
  assign res.has_byte   = has;
  assign res.frame_end  = fend;
  assign res.event_res  = ev;

  a_empty_is_idle: assert property (@(posedge clk) disable iff (rst)
    (buffer_left == 16'd0) |-> (phase == PH_IDLE))
    else $error("buffer exhausted but parser not idle");

  a_event_no_byte: assert property (@(posedge clk) disable iff (rst)
    (step && ev != usbrxd_pkg::EV_NONE) |-> !has)
    else $error("event reported together with a data byte");

  a_end_has_byte: assert property (@(posedge clk) disable iff (rst)
    fend |-> (has && phase == PH_DATA))
    else $error("frame end outside data phase");

  a_pad_from_status: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAD) |-> (pad_left != 2'd0))
    else $error("pad phase with nothing to pad");

endmodule

[src/usb_ether_rx_deframer.sv]
// USB Ethernet bulk receive deframer, top level: config register,
// parser and two-entry result buffer. Depends on usbrxd_pkg, usbrxd_parser.
//
// Takes one buffer byte per clock while in_stall is low; each result is
// registered into the output register, or into the skid entry when the
// output is stalled. Results sit in an output register backed by a
// skid entry, so a byte is still taken while a result waits; in_stall rises
// only once the skid entry is occupied. frame_format is written through the
// cfg channel (always ready) and should change only between buffers.
module usb_ether_rx_deframer #(
  parameter int MAX_BUFFER = usbrxd_pkg::MAX_BUFFER_DEF,
  parameter int MIN_FRAME  = usbrxd_pkg::MIN_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  usbrxd_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output usbrxd_pkg::out_item_t out_data
);

  logic [1:0]            frame_format;
  logic                  accept;
  logic                  res_valid;
  usbrxd_pkg::out_item_t res;
  logic                  skid_valid;
  usbrxd_pkg::out_item_t skid_item;
  logic                  pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_format <= usbrxd_pkg::FMT_PLAIN;
    end else if (cfg_valid && cfg_ready) begin
      frame_format <= cfg_data;
    end
  end

  usbrxd_parser #(
    .MAX_BUFFER(MAX_BUFFER),
    .MIN_FRAME (MIN_FRAME)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .item        (in_data),
    .frame_format(frame_format),
    .res_valid   (res_valid),
    .res         (res)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_item;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || pop) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_item  <= res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry occupied while output register empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid entry filled without a stalled output");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !accept)
    else $error("transaction accepted with both result entries full");

endmodule
